// ----- src/dcfd_pkg.sv -----
package dcfd_pkg;

    localparam int ACTUATOR_BITS = 12;
    localparam int THROTTLE_BITS = 12;

    localparam int BYTE_W       = 8;
    localparam int PAYLOAD_LEN  = 12;
    localparam int FRAME_W      = PAYLOAD_LEN * BYTE_W;
    localparam int HELD_W       = $clog2(PAYLOAD_LEN + 1);
    localparam int FLOAT_W      = 32;
    localparam int EXP_W        = 8;
    localparam int MAN_W        = 23;
    localparam int F_BIAS       = 127;
    localparam int Q_FRAC       = 23;
    localparam int Q_W          = Q_FRAC + 1;
    localparam int CFG_DATA_W   = 24;
    localparam int CFG_IDX_W    = 3;

    localparam int STEER_PROD_W = Q_W + ACTUATOR_BITS + 2;
    localparam int STEER_NUM_W  = STEER_PROD_W + 1;
    localparam int BRAKE_PROD_W = Q_W + ACTUATOR_BITS;
    localparam int THR_PROD_W   = Q_W + THROTTLE_BITS;

    localparam logic [CFG_IDX_W-1:0] CFG_STEER_CENTER    = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_ACTUATOR_MAX    = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_ACTUATOR_MIN    = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] CFG_THROTTLE_CAP    = CFG_IDX_W'(3);
    localparam logic [CFG_IDX_W-1:0] CFG_BRAKE_THRESHOLD = CFG_IDX_W'(4);
    localparam logic [CFG_IDX_W-1:0] CFG_SPEED_DEADZONE  = CFG_IDX_W'(5);

    localparam logic [ACTUATOR_BITS-1:0] RST_STEER_CENTER = ACTUATOR_BITS'(2048);
    localparam logic [ACTUATOR_BITS-1:0] RST_ACTUATOR_MAX = ACTUATOR_BITS'(4095);
    localparam logic [ACTUATOR_BITS-1:0] RST_ACTUATOR_MIN = ACTUATOR_BITS'(0);
    localparam logic [THROTTLE_BITS-1:0] RST_THROTTLE_CAP = THROTTLE_BITS'(4095);
    localparam logic [CFG_DATA_W-1:0]    RST_BRAKE_THRESH = CFG_DATA_W'(419430);
    localparam logic [CFG_DATA_W-1:0]    RST_SPEED_DZ     = CFG_DATA_W'(251658);

    typedef enum logic [1:0] {
        ST_DRIVE  = 2'd0,
        ST_BRAKE  = 2'd1,
        ST_REJECT = 2'd2
    } t_status;

    typedef logic [FRAME_W-1:0] t_frame;

    typedef struct packed {
        logic [ACTUATOR_BITS-1:0] steer_center;
        logic [ACTUATOR_BITS-1:0] actuator_max;
        logic [ACTUATOR_BITS-1:0] actuator_min;
        logic [THROTTLE_BITS-1:0] throttle_cap;
        logic [CFG_DATA_W-1:0]    brake_threshold;
        logic [CFG_DATA_W-1:0]    speed_deadzone;
    } t_cfg;

    typedef struct packed {
        logic           ok;
        logic           neg;
        logic [Q_W-1:0] mag;
    } t_qval;

endpackage

// ----- src/dcfd_front.sv -----
module dcfd_front (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic [dcfd_pkg::BYTE_W-1:0]  i_rx_byte,
    output logic                         o_frame_valid,
    input  logic                         i_frame_ready,
    output dcfd_pkg::t_frame             o_frame
);

    logic [dcfd_pkg::BYTE_W-1:0] r_win [0:dcfd_pkg::PAYLOAD_LEN-1];
    logic [dcfd_pkg::HELD_W-1:0] r_held;
    logic [dcfd_pkg::BYTE_W-1:0] r_sum;

    logic accept;
    logic full;
    logic good;

    assign full    = (r_held == dcfd_pkg::HELD_W'(dcfd_pkg::PAYLOAD_LEN));
    assign good    = full && (r_sum == i_rx_byte);
    assign o_ready = !full || i_frame_ready;
    assign accept  = i_valid && o_ready;
    assign o_frame_valid = i_valid && good;

    always_comb begin
        for (int i = 0; i < dcfd_pkg::PAYLOAD_LEN; i++) begin
            o_frame[i*dcfd_pkg::BYTE_W +: dcfd_pkg::BYTE_W] = r_win[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held <= '0;
            r_sum  <= '0;
        end else if (accept) begin
            if (!full) begin
                r_held <= r_held + 1'b1;
                r_sum  <= r_sum + i_rx_byte;
            end else if (good) begin
                r_held <= '0;
                r_sum  <= '0;
            end else begin
                r_sum  <= r_sum - r_win[0] + i_rx_byte;
            end
        end
    end

    // oldest byte sits at index 0 once the window is full
    always_ff @(posedge i_clk) begin
        if (accept && !good) begin
            for (int i = 0; i < dcfd_pkg::PAYLOAD_LEN - 1; i++) begin
                r_win[i] <= r_win[i+1];
            end
            r_win[dcfd_pkg::PAYLOAD_LEN-1] <= i_rx_byte;
        end
    end

endmodule

// ----- src/dcfd_queue.sv -----
module dcfd_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push_valid,
    output logic             o_push_ready,
    input  dcfd_pkg::t_frame i_push_data,
    output logic             o_pop_valid,
    input  logic             i_pop_ready,
    output dcfd_pkg::t_frame o_pop_data
);

    logic             r_head_valid;
    logic             r_tail_valid;
    dcfd_pkg::t_frame r_head;
    dcfd_pkg::t_frame r_tail;

    logic push;
    logic pop;

    assign o_push_ready = !r_tail_valid;
    assign o_pop_valid  = r_head_valid;
    assign o_pop_data   = r_head;
    assign push = i_push_valid && !r_tail_valid;
    assign pop  = r_head_valid && i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head_valid <= 1'b0;
            r_tail_valid <= 1'b0;
        end else if (pop) begin
            r_head_valid <= r_tail_valid || push;
            r_tail_valid <= 1'b0;
        end else if (push) begin
            if (!r_head_valid) begin
                r_head_valid <= 1'b1;
            end else begin
                r_tail_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_head <= r_tail_valid ? r_tail : i_push_data;
        end else if (push) begin
            if (!r_head_valid) begin
                r_head <= i_push_data;
            end else begin
                r_tail <= i_push_data;
            end
        end
    end

endmodule

// ----- src/dcfd_back.sv -----
module dcfd_back (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  dcfd_pkg::t_cfg                     i_cfg,
    input  logic                               i_frame_valid,
    output logic                               o_frame_ready,
    input  dcfd_pkg::t_frame                   i_frame,
    output logic                               o_valid,
    input  logic                               i_ready,
    output logic [1:0]                         o_frame_status,
    output logic [dcfd_pkg::ACTUATOR_BITS-1:0] o_steer_target,
    output logic [dcfd_pkg::ACTUATOR_BITS-1:0] o_brake_target,
    output logic [dcfd_pkg::THROTTLE_BITS-1:0] o_throttle_level,
    output logic                               o_throttle_immediate,
    output logic                               o_direction_update,
    output logic                               o_direction_forward
);

    localparam int ACT_W = dcfd_pkg::ACTUATOR_BITS;
    localparam int THR_W = dcfd_pkg::THROTTLE_BITS;
    localparam int Q_W   = dcfd_pkg::Q_W;
    localparam int FW    = dcfd_pkg::FLOAT_W;

    function automatic dcfd_pkg::t_qval f_to_q(input logic [FW-1:0] bits);
        dcfd_pkg::t_qval              q;
        logic [dcfd_pkg::EXP_W-1:0]   e;
        logic [dcfd_pkg::MAN_W-1:0]   man;
        logic [dcfd_pkg::EXP_W-1:0]   sh;
        logic [Q_W-1:0]               mag;
        e   = bits[dcfd_pkg::MAN_W +: dcfd_pkg::EXP_W];
        man = bits[dcfd_pkg::MAN_W-1:0];
        sh  = dcfd_pkg::EXP_W'(dcfd_pkg::F_BIAS) - e;
        if (e == '0) begin
            mag = '0;
        end else if (sh >= dcfd_pkg::EXP_W'(Q_W)) begin
            mag = '0;
        end else begin
            mag = {1'b1, man} >> sh[$clog2(Q_W)-1:0];
        end
        q.ok  = (e < dcfd_pkg::EXP_W'(dcfd_pkg::F_BIAS)) ||
                ((e == dcfd_pkg::EXP_W'(dcfd_pkg::F_BIAS)) && (man == '0));
        q.neg = bits[FW-1] && (mag != '0);
        q.mag = mag;
        return q;
    endfunction

    logic rdy1, rdy2, rdy3;

    // stage 1: float to Q1.23
    logic            r1_valid;
    dcfd_pkg::t_qval r1_s, r1_v, r1_a;

    // stage 2: products and compares
    logic                                   r2_valid;
    logic                                   r2_ok;
    logic                                   r2_brake;
    logic                                   r2_dead;
    logic                                   r2_fwd;
    logic signed [dcfd_pkg::STEER_PROD_W-1:0] r2_steer_prod;
    logic [dcfd_pkg::BRAKE_PROD_W-1:0]      r2_brake_prod;
    logic [dcfd_pkg::THR_PROD_W-1:0]        r2_thr_prod;

    logic signed [ACT_W:0]                  n_k;
    logic signed [Q_W:0]                    n_mag_s;
    logic signed [dcfd_pkg::STEER_PROD_W-1:0] n_steer_prod;

    // stage 3: output register
    logic                r_valid;
    dcfd_pkg::t_status   r_status;
    logic [ACT_W-1:0]    r_steer;
    logic [ACT_W-1:0]    r_brake;
    logic [THR_W-1:0]    r_thr;
    logic                r_imm;
    logic                r_upd;
    logic                r_fwd;

    logic signed [dcfd_pkg::STEER_NUM_W-1:0] n_base;
    logic signed [dcfd_pkg::STEER_NUM_W-1:0] n_num;
    logic [ACT_W-1:0]    n_steer;
    logic [ACT_W:0]      n_raw;
    logic [ACT_W-1:0]    n_brake;
    logic [THR_W:0]      n_lvl;
    logic [THR_W-1:0]    n_thr;

    assign rdy3 = !r_valid || i_ready;
    assign rdy2 = !r2_valid || rdy3;
    assign rdy1 = !r1_valid || rdy2;
    assign o_frame_ready = rdy1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else if (rdy1) begin
            r1_valid <= i_frame_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy1) begin
            r1_s <= f_to_q(i_frame[0 +: FW]);
            r1_v <= f_to_q(i_frame[FW +: FW]);
            r1_a <= f_to_q(i_frame[2*FW +: FW]);
        end
    end

    always_comb begin
        n_mag_s = $signed({1'b0, r1_s.mag});
        if (r1_s.neg) begin
            n_k = -$signed({1'b0, i_cfg.steer_center});
        end else begin
            n_k = $signed({1'b0, i_cfg.actuator_max}) - $signed({1'b0, i_cfg.steer_center});
        end
        n_steer_prod = n_mag_s * n_k;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_valid <= 1'b0;
        end else if (rdy2) begin
            r2_valid <= r1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy2) begin
            r2_ok         <= r1_s.ok && r1_v.ok && r1_a.ok;
            r2_brake      <= r1_a.neg && (r1_a.mag > i_cfg.brake_threshold);
            r2_dead       <= r1_v.mag < i_cfg.speed_deadzone;
            r2_fwd        <= !r1_v.neg;
            r2_steer_prod <= n_steer_prod;
            r2_brake_prod <= r1_a.mag * i_cfg.actuator_max;
            r2_thr_prod   <= r1_v.mag * i_cfg.throttle_cap;
        end
    end

    always_comb begin
        n_base = $signed({{(dcfd_pkg::STEER_NUM_W - ACT_W - dcfd_pkg::Q_FRAC){1'b0}},
                          i_cfg.steer_center, {dcfd_pkg::Q_FRAC{1'b0}}});
        n_num  = n_base + dcfd_pkg::STEER_NUM_W'(r2_steer_prod);
        n_steer = n_num[dcfd_pkg::STEER_NUM_W-1] ? '0 : n_num[dcfd_pkg::Q_FRAC +: ACT_W];

        n_raw = r2_brake_prod[dcfd_pkg::Q_FRAC +: ACT_W+1];
        if (n_raw < {1'b0, i_cfg.actuator_min}) begin
            n_brake = i_cfg.actuator_min;
        end else if (n_raw > {1'b0, i_cfg.actuator_max}) begin
            n_brake = i_cfg.actuator_max;
        end else begin
            n_brake = n_raw[ACT_W-1:0];
        end

        n_lvl = r2_thr_prod[dcfd_pkg::Q_FRAC +: THR_W+1];
        if (n_lvl > {1'b0, i_cfg.throttle_cap}) begin
            n_thr = i_cfg.throttle_cap;
        end else begin
            n_thr = n_lvl[THR_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (rdy3) begin
            r_valid <= r2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy3) begin
            r_brake <= i_cfg.actuator_min;
            r_thr   <= '0;
            r_imm   <= 1'b0;
            r_upd   <= 1'b0;
            r_fwd   <= 1'b0;
            if (!r2_ok) begin
                r_status <= dcfd_pkg::ST_REJECT;
                r_steer  <= '0;
            end else if (r2_brake) begin
                r_status <= dcfd_pkg::ST_BRAKE;
                r_steer  <= n_steer;
                r_brake  <= n_brake;
                r_imm    <= 1'b1;
            end else begin
                r_status <= dcfd_pkg::ST_DRIVE;
                r_steer  <= n_steer;
                if (!r2_dead) begin
                    r_thr <= n_thr;
                    r_upd <= 1'b1;
                    r_fwd <= r2_fwd;
                end
            end
        end
    end

    assign o_valid              = r_valid;
    assign o_frame_status       = r_status;
    assign o_steer_target       = r_steer;
    assign o_brake_target       = r_brake;
    assign o_throttle_level     = r_thr;
    assign o_throttle_immediate = r_imm;
    assign o_direction_update   = r_upd;
    assign o_direction_forward  = r_fwd;

endmodule

// ----- src/drive_command_frame_decoder_top.sv -----
// Drive command frame decoder. Takes one serial byte per cycle into a 12-byte window
// (steer, speed, accel as little-endian float32) plus a checksum byte; a frame whose
// 8-bit sum matches is handed through a two-entry queue to a three-stage decode
// pipeline, a mismatch slides the window by one byte. Input throughput is one byte
// per cycle; it stalls only on a checksum byte while the queue is full. A frame is
// registered into the queue head and then into the three decode stages; the decode
// pipeline delivers one result per cycle while i_ready is high.
// Configuration registers may be written only while no frame is in flight.
module drive_command_frame_decoder_top (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic [dcfd_pkg::BYTE_W-1:0]         i_rx_byte,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic [1:0]                          o_frame_status,
    output logic [dcfd_pkg::ACTUATOR_BITS-1:0]  o_steer_target,
    output logic [dcfd_pkg::ACTUATOR_BITS-1:0]  o_brake_target,
    output logic [dcfd_pkg::THROTTLE_BITS-1:0]  o_throttle_level,
    output logic                                o_throttle_immediate,
    output logic                                o_direction_update,
    output logic                                o_direction_forward,
    input  logic                                i_cfg_wr_en,
    input  logic [dcfd_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [dcfd_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    dcfd_pkg::t_cfg   r_cfg;
    logic             front_valid;
    logic             front_ready;
    dcfd_pkg::t_frame front_frame;
    logic             back_valid;
    logic             back_ready;
    dcfd_pkg::t_frame back_frame;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.steer_center    <= dcfd_pkg::RST_STEER_CENTER;
            r_cfg.actuator_max    <= dcfd_pkg::RST_ACTUATOR_MAX;
            r_cfg.actuator_min    <= dcfd_pkg::RST_ACTUATOR_MIN;
            r_cfg.throttle_cap    <= dcfd_pkg::RST_THROTTLE_CAP;
            r_cfg.brake_threshold <= dcfd_pkg::RST_BRAKE_THRESH;
            r_cfg.speed_deadzone  <= dcfd_pkg::RST_SPEED_DZ;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                dcfd_pkg::CFG_STEER_CENTER: begin
                    r_cfg.steer_center <= i_cfg_data[dcfd_pkg::ACTUATOR_BITS-1:0];
                end
                dcfd_pkg::CFG_ACTUATOR_MAX: begin
                    r_cfg.actuator_max <= i_cfg_data[dcfd_pkg::ACTUATOR_BITS-1:0];
                end
                dcfd_pkg::CFG_ACTUATOR_MIN: begin
                    r_cfg.actuator_min <= i_cfg_data[dcfd_pkg::ACTUATOR_BITS-1:0];
                end
                dcfd_pkg::CFG_THROTTLE_CAP: begin
                    r_cfg.throttle_cap <= i_cfg_data[dcfd_pkg::THROTTLE_BITS-1:0];
                end
                dcfd_pkg::CFG_BRAKE_THRESHOLD: begin
                    r_cfg.brake_threshold <= i_cfg_data;
                end
                dcfd_pkg::CFG_SPEED_DEADZONE: begin
                    r_cfg.speed_deadzone <= i_cfg_data;
                end
                default: begin
                end
            endcase
        end
    end

    dcfd_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_rx_byte     (i_rx_byte),
        .o_frame_valid (front_valid),
        .i_frame_ready (front_ready),
        .o_frame       (front_frame)
    );

    dcfd_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (front_valid),
        .o_push_ready (front_ready),
        .i_push_data  (front_frame),
        .o_pop_valid  (back_valid),
        .i_pop_ready  (back_ready),
        .o_pop_data   (back_frame)
    );

    dcfd_back u_back (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_cfg                (r_cfg),
        .i_frame_valid        (back_valid),
        .o_frame_ready        (back_ready),
        .i_frame              (back_frame),
        .o_valid              (o_valid),
        .i_ready              (i_ready),
        .o_frame_status       (o_frame_status),
        .o_steer_target       (o_steer_target),
        .o_brake_target       (o_brake_target),
        .o_throttle_level     (o_throttle_level),
        .o_throttle_immediate (o_throttle_immediate),
        .o_direction_update   (o_direction_update),
        .o_direction_forward  (o_direction_forward)
    );

endmodule

// ----- tb/tb_top.sv -----
module tb_top;

    localparam int CYCLE_LIMIT  = 300000;
    localparam int DRAIN_CYCLES = 12;
    localparam int RANDOM_BYTES = 1150;
    localparam int NARROW_HI_W  = dcfd_pkg::CFG_DATA_W - dcfd_pkg::ACTUATOR_BITS;

    localparam logic [dcfd_pkg::CFG_IDX_W-1:0] CFG_SPARE_LO = dcfd_pkg::CFG_IDX_W'(6);
    localparam logic [dcfd_pkg::CFG_IDX_W-1:0] CFG_SPARE_HI = dcfd_pkg::CFG_IDX_W'(7);

    localparam longint Q_ONE = 64'sd8388608;

    localparam logic [31:0] F_ZERO      = 32'h0000_0000;
    localparam logic [31:0] F_NEG_ZERO  = 32'h8000_0000;
    localparam logic [31:0] F_POS_ONE   = 32'h3F80_0000;
    localparam logic [31:0] F_NEG_ONE   = 32'hBF80_0000;
    localparam logic [31:0] F_POS_HALF  = 32'h3F00_0000;
    localparam logic [31:0] F_NEG_HALF  = 32'hBF00_0000;
    localparam logic [31:0] F_ABOVE_ONE = 32'h3F80_0001;
    localparam logic [31:0] F_NAN       = 32'h7FC0_0000;
    localparam logic [31:0] F_POS_INF   = 32'h7F80_0000;
    localparam logic [31:0] F_NEG_INF   = 32'hFF80_0000;
    localparam logic [31:0] F_SUBNORM   = 32'h8000_0001;
    localparam logic [31:0] F_TINY      = 32'h3300_0000;

    typedef struct {
        dcfd_pkg::t_status                  status;
        logic [dcfd_pkg::ACTUATOR_BITS-1:0] steer;
        logic [dcfd_pkg::ACTUATOR_BITS-1:0] brake;
        logic [dcfd_pkg::THROTTLE_BITS-1:0] throttle;
        logic                               immediate;
        logic                               dir_update;
        logic                               dir_forward;
    } t_cmd_result;

    logic                               i_clk;
    logic                               i_rst_n;
    logic                               i_valid;
    logic                               o_ready;
    logic [dcfd_pkg::BYTE_W-1:0]        i_rx_byte;
    logic                               o_valid;
    logic                               i_ready;
    logic [1:0]                         o_frame_status;
    logic [dcfd_pkg::ACTUATOR_BITS-1:0] o_steer_target;
    logic [dcfd_pkg::ACTUATOR_BITS-1:0] o_brake_target;
    logic [dcfd_pkg::THROTTLE_BITS-1:0] o_throttle_level;
    logic                               o_throttle_immediate;
    logic                               o_direction_update;
    logic                               o_direction_forward;
    logic                               i_cfg_wr_en;
    logic [dcfd_pkg::CFG_IDX_W-1:0]     i_cfg_index;
    logic [dcfd_pkg::CFG_DATA_W-1:0]    i_cfg_data;

    drive_command_frame_decoder_top u_dut (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_valid              (i_valid),
        .o_ready              (o_ready),
        .i_rx_byte            (i_rx_byte),
        .o_valid              (o_valid),
        .i_ready              (i_ready),
        .o_frame_status       (o_frame_status),
        .o_steer_target       (o_steer_target),
        .o_brake_target       (o_brake_target),
        .o_throttle_level     (o_throttle_level),
        .o_throttle_immediate (o_throttle_immediate),
        .o_direction_update   (o_direction_update),
        .o_direction_forward  (o_direction_forward),
        .i_cfg_wr_en          (i_cfg_wr_en),
        .i_cfg_index          (i_cfg_index),
        .i_cfg_data           (i_cfg_data)
    );

    // decoder shadow state
    logic [7:0]                         win_bytes [13];
    int                                 win_held;
    logic [7:0]                         win_chk;
    logic [dcfd_pkg::ACTUATOR_BITS-1:0] cfg_center;
    logic [dcfd_pkg::ACTUATOR_BITS-1:0] cfg_amax;
    logic [dcfd_pkg::ACTUATOR_BITS-1:0] cfg_amin;
    logic [dcfd_pkg::THROTTLE_BITS-1:0] cfg_tcap;
    logic [dcfd_pkg::CFG_DATA_W-1:0]    cfg_bthr;
    logic [dcfd_pkg::CFG_DATA_W-1:0]    cfg_dz;

    t_cmd_result pending_cmds[$];
    int          mismatches = 0;
    int          sent_bytes = 0;
    int          cycle_count = 0;
    bit          idle_en = 1'b1;
    bit          stall_en = 1'b1;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    function automatic bit float_to_q(input logic [31:0] bits, output longint q);
        logic [7:0]  e;
        logic [22:0] m;
        longint      mag;
        int          sh;
        e = bits[30:23];
        m = bits[22:0];
        if (e == 8'hFF || e > 8'd127 || (e == 8'd127 && m != 23'd0))
            return 1'b0;
        if (e == 8'd0) begin
            mag = 0;
        end else begin
            sh = 127 - int'(e);
            mag = (sh >= 24) ? 0 : (longint'({1'b1, m}) >> sh);
        end
        q = bits[31] ? -mag : mag;
        return 1'b1;
    endfunction

    function automatic t_cmd_result decode_window();
        t_cmd_result r;
        longint      s, v, a, num, vm, lvl, raw;
        bit          ok_s, ok_v, ok_a;
        r.status      = dcfd_pkg::ST_DRIVE;
        r.steer       = '0;
        r.brake       = cfg_amin;
        r.throttle    = '0;
        r.immediate   = 1'b0;
        r.dir_update  = 1'b0;
        r.dir_forward = 1'b0;
        ok_s = float_to_q({win_bytes[3], win_bytes[2], win_bytes[1], win_bytes[0]}, s);
        ok_v = float_to_q({win_bytes[7], win_bytes[6], win_bytes[5], win_bytes[4]}, v);
        ok_a = float_to_q({win_bytes[11], win_bytes[10], win_bytes[9], win_bytes[8]}, a);
        if (!(ok_s && ok_v && ok_a)) begin
            r.status = dcfd_pkg::ST_REJECT;
            return r;
        end
        if (s <= 0)
            num = (longint'(cfg_center) <<< 23) + s * longint'(cfg_center);
        else
            num = (longint'(cfg_center) <<< 23)
                + s * (longint'(cfg_amax) - longint'(cfg_center));
        r.steer = (num < 0) ? '0 : dcfd_pkg::ACTUATOR_BITS'(num >>> 23);
        if (a < -longint'(cfg_bthr)) begin
            raw = ((-a) * longint'(cfg_amax)) >>> 23;
            if (raw < longint'(cfg_amin))
                raw = longint'(cfg_amin);
            else if (raw > longint'(cfg_amax))
                raw = longint'(cfg_amax);
            r.status    = dcfd_pkg::ST_BRAKE;
            r.brake     = dcfd_pkg::ACTUATOR_BITS'(raw);
            r.immediate = 1'b1;
            return r;
        end
        vm = (v < 0) ? -v : v;
        if (vm < longint'(cfg_dz))
            return r;
        lvl = (vm * longint'(cfg_tcap)) >>> 23;
        if (lvl > longint'(cfg_tcap))
            lvl = longint'(cfg_tcap);
        r.throttle    = dcfd_pkg::THROTTLE_BITS'(lvl);
        r.dir_update  = 1'b1;
        r.dir_forward = (v >= 0);
        return r;
    endfunction

    function automatic bit absorb_byte(input logic [7:0] b, output t_cmd_result r);
        if (win_held >= dcfd_pkg::PAYLOAD_LEN) begin
            win_bytes[dcfd_pkg::PAYLOAD_LEN] = b;
            if (win_chk == b) begin
                r = decode_window();
                win_held = 0;
                win_chk = 8'd0;
                return 1'b1;
            end
            win_chk = win_chk - win_bytes[0] + b;
            for (int i = 0; i < dcfd_pkg::PAYLOAD_LEN; i++)
                win_bytes[i] = win_bytes[i+1];
            win_held = dcfd_pkg::PAYLOAD_LEN;
            return 1'b0;
        end
        win_bytes[win_held] = b;
        win_chk = win_chk + b;
        win_held = win_held + 1;
        return 1'b0;
    endfunction

    // float whose Q1.23 truncation is exactly mag, for mag in 0..Q_ONE
    function automatic logic [31:0] q_to_float(input bit neg, input longint mag);
        int          p;
        logic [31:0] f;
        longint      m;
        m = (mag > Q_ONE) ? Q_ONE : mag;
        if (m <= 0)
            return {neg, 31'd0};
        p = 0;
        for (int i = 0; i < 24; i++)
            if (m[i]) p = i;
        f[31]    = neg;
        f[30:23] = 8'(104 + p);
        f[22:0]  = 23'(m << (23 - p));
        return f;
    endfunction

    function automatic logic [31:0] rand_cmd();
        int          k;
        logic [31:0] f;
        k = $urandom_range(0, 99);
        f = $urandom;
        if (k < 72) begin
            f[30:23] = 8'($urandom_range(104, 126));
        end else if (k < 78) begin
            f[30:0] = F_POS_ONE[30:0];
        end else if (k < 84) begin
            f[30:23] = 8'd0;
        end else if (k < 88) begin
            f[30:23] = 8'($urandom_range(1, 103));
        end else if (k < 92) begin
            f[30:23] = 8'd127;
            if (f[22:0] == 23'd0) f[0] = 1'b1;
        end else if (k < 94) begin
            f[30:23] = 8'($urandom_range(128, 254));
        end else if (k < 96) begin
            f[30:23] = 8'hFF;
        end
        return f;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        mismatches++;
        $display("mismatch %s: got %0d want %0d (cycle %0d)", what, got, want, cycle_count);
    endtask

    task automatic check_result();
        t_cmd_result w;
        if (pending_cmds.size() == 0) begin
            report_mismatch("unexpected item, status", o_frame_status, -1);
            return;
        end
        w = pending_cmds.pop_front();
        if (o_frame_status !== w.status)
            report_mismatch("frame_status", o_frame_status, w.status);
        if (o_steer_target !== w.steer)
            report_mismatch("steer_target", o_steer_target, w.steer);
        if (o_brake_target !== w.brake)
            report_mismatch("brake_target", o_brake_target, w.brake);
        if (o_throttle_level !== w.throttle)
            report_mismatch("throttle_level", o_throttle_level, w.throttle);
        if (o_throttle_immediate !== w.immediate)
            report_mismatch("throttle_immediate", o_throttle_immediate, w.immediate);
        if (o_direction_update !== w.dir_update)
            report_mismatch("direction_update", o_direction_update, w.dir_update);
        if (o_direction_forward !== w.dir_forward)
            report_mismatch("direction_forward", o_direction_forward, w.dir_forward);
    endtask

    initial begin : result_sink
        int stall;
        i_ready = 1'b0;
        wait (i_rst_n === 1'b1);
        @(negedge i_clk);
        forever begin
            stall = stall_en ? $urandom_range(0, 10) : 0;
            if (stall > 0) begin
                i_ready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            i_ready <= 1'b1;
            do @(posedge i_clk); while (o_valid !== 1'b1);
            check_result();
            @(negedge i_clk);
        end
    end

    task automatic send_byte(input logic [7:0] b);
        int          gap;
        t_cmd_result r;
        gap = idle_en ? $urandom_range(0, 10) : 0;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid   <= 1'b1;
        i_rx_byte <= b;
        do @(posedge i_clk); while (o_ready !== 1'b1);
        if (absorb_byte(b, r))
            pending_cmds.push_back(r);
        sent_bytes++;
        @(negedge i_clk);
    endtask

    task automatic send_frame(input logic [31:0] st, input logic [31:0] sp,
                              input logic [31:0] ac, input bit bad);
        logic [95:0] payload;
        logic [7:0]  chk;
        payload = {ac, sp, st};
        chk = 8'd0;
        for (int i = 0; i < dcfd_pkg::PAYLOAD_LEN; i++)
            chk = chk + payload[8*i +: 8];
        if (bad)
            chk = chk ^ 8'($urandom_range(1, 255));
        for (int i = 0; i < dcfd_pkg::PAYLOAD_LEN; i++)
            send_byte(payload[8*i +: 8]);
        send_byte(chk);
    endtask

    task automatic noise_burst(input int n);
        for (int i = 0; i < n; i++)
            send_byte(8'($urandom));
    endtask

    // returns once nothing is in flight
    task automatic wait_idle();
        i_valid <= 1'b0;
        while (pending_cmds.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic cfg_write(input logic [dcfd_pkg::CFG_IDX_W-1:0] idx,
                             input logic [dcfd_pkg::CFG_DATA_W-1:0] data);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
        @(negedge i_clk);
        case (idx)
            dcfd_pkg::CFG_STEER_CENTER:    cfg_center = data[dcfd_pkg::ACTUATOR_BITS-1:0];
            dcfd_pkg::CFG_ACTUATOR_MAX:    cfg_amax   = data[dcfd_pkg::ACTUATOR_BITS-1:0];
            dcfd_pkg::CFG_ACTUATOR_MIN:    cfg_amin   = data[dcfd_pkg::ACTUATOR_BITS-1:0];
            dcfd_pkg::CFG_THROTTLE_CAP:    cfg_tcap   = data[dcfd_pkg::THROTTLE_BITS-1:0];
            dcfd_pkg::CFG_BRAKE_THRESHOLD: cfg_bthr   = data;
            dcfd_pkg::CFG_SPEED_DEADZONE:  cfg_dz     = data;
            default: ;
        endcase
    endtask

    function automatic logic [dcfd_pkg::CFG_DATA_W-1:0] pick_narrow();
        int k;
        k = $urandom_range(0, 3);
        // upper bits are don't-care for the 12-bit registers
        pick_narrow[dcfd_pkg::CFG_DATA_W-1:dcfd_pkg::ACTUATOR_BITS] = NARROW_HI_W'($urandom);
        case (k)
            0:       pick_narrow[dcfd_pkg::ACTUATOR_BITS-1:0] = '0;
            1:       pick_narrow[dcfd_pkg::ACTUATOR_BITS-1:0] = '1;
            default: pick_narrow[dcfd_pkg::ACTUATOR_BITS-1:0] =
                         dcfd_pkg::ACTUATOR_BITS'($urandom);
        endcase
    endfunction

    function automatic logic [dcfd_pkg::CFG_DATA_W-1:0] pick_q();
        int k;
        k = $urandom_range(0, 7);
        case (k)
            0:       return '0;
            1:       return dcfd_pkg::CFG_DATA_W'(Q_ONE);
            2, 3:    return dcfd_pkg::CFG_DATA_W'($urandom_range(0, 8388608));
            default: return dcfd_pkg::CFG_DATA_W'($urandom_range(0, 1048575));
        endcase
    endfunction

    task automatic randomize_config();
        cfg_write(dcfd_pkg::CFG_STEER_CENTER, pick_narrow());
        cfg_write(dcfd_pkg::CFG_ACTUATOR_MAX, pick_narrow());
        cfg_write(dcfd_pkg::CFG_ACTUATOR_MIN, pick_narrow());
        cfg_write(dcfd_pkg::CFG_THROTTLE_CAP, pick_narrow());
        cfg_write(dcfd_pkg::CFG_BRAKE_THRESHOLD, pick_q());
        cfg_write(dcfd_pkg::CFG_SPEED_DEADZONE, pick_q());
        if ($urandom_range(0, 3) == 0)
            cfg_write($urandom_range(0, 1) ? CFG_SPARE_LO : CFG_SPARE_HI,
                      dcfd_pkg::CFG_DATA_W'($urandom));
    endtask

    task automatic random_frame();
        int     k;
        longint d;
        k = $urandom_range(0, 9);
        d = longint'($urandom_range(0, 4)) - 2;
        if (k < 6)
            send_frame(rand_cmd(), rand_cmd(), rand_cmd(), 1'b0);
        else if (k < 8)
            send_frame(rand_cmd(), rand_cmd(), q_to_float(1'b1, longint'(cfg_bthr) + d), 1'b0);
        else
            send_frame(rand_cmd(), q_to_float(1'($urandom_range(0, 1)), longint'(cfg_dz) + d),
                       q_to_float(1'($urandom_range(0, 1)), $urandom_range(0, 300000)), 1'b0);
    endtask

    task automatic test_default_frames();
        send_frame(F_ZERO, F_ZERO, F_ZERO, 1'b0);
        send_frame(F_POS_ONE, F_POS_ONE, F_ZERO, 1'b0);
        send_frame(F_NEG_ONE, F_NEG_ONE, F_ZERO, 1'b0);
        send_frame(F_POS_HALF, F_POS_ONE, F_NEG_ONE, 1'b0);
        send_frame(F_NEG_HALF, F_POS_HALF, q_to_float(1'b1, longint'(cfg_bthr) + 1), 1'b0);
        send_frame(F_ZERO, F_NEG_HALF, q_to_float(1'b1, longint'(cfg_bthr)), 1'b0);
        send_frame(F_ZERO, q_to_float(1'b0, longint'(cfg_dz)), F_ZERO, 1'b0);
        send_frame(F_ZERO, q_to_float(1'b1, longint'(cfg_dz) - 1), F_ZERO, 1'b0);
        send_frame(F_NAN, F_ZERO, F_ZERO, 1'b0);
        send_frame(F_ZERO, F_POS_INF, F_ZERO, 1'b0);
        send_frame(F_ZERO, F_ZERO, F_NEG_INF, 1'b0);
        send_frame(F_ABOVE_ONE, F_ZERO, F_ZERO, 1'b0);
        send_frame(F_TINY, F_NEG_ZERO, F_SUBNORM, 1'b0);
    endtask

    task automatic test_stream_resync();
        send_frame(rand_cmd(), rand_cmd(), rand_cmd(), 1'b1);
        send_frame(F_POS_HALF, F_POS_HALF, F_ZERO, 1'b0);
        noise_burst(5);
        send_frame(F_NEG_HALF, F_POS_ONE, F_ZERO, 1'b0);
        send_frame(F_ZERO, F_ZERO, F_NEG_ONE, 1'b0);
        send_frame(F_POS_ONE, F_NEG_HALF, F_ZERO, 1'b0);
    endtask

    task automatic test_register_extremes();
        wait_idle();
        cfg_write(dcfd_pkg::CFG_STEER_CENTER, {12'hABC, 12'd0});
        cfg_write(dcfd_pkg::CFG_ACTUATOR_MAX, 24'd4095);
        send_frame(F_NEG_ONE, F_ZERO, F_ZERO, 1'b0);
        send_frame(F_POS_ONE, F_ZERO, F_ZERO, 1'b0);
        wait_idle();
        cfg_write(dcfd_pkg::CFG_STEER_CENTER, 24'd4095);
        cfg_write(dcfd_pkg::CFG_ACTUATOR_MAX, {12'h5A5, 12'd0});
        cfg_write(dcfd_pkg::CFG_ACTUATOR_MIN, 24'd4095);
        cfg_write(dcfd_pkg::CFG_THROTTLE_CAP, 24'd0);
        cfg_write(dcfd_pkg::CFG_BRAKE_THRESHOLD, 24'd0);
        cfg_write(dcfd_pkg::CFG_SPEED_DEADZONE, 24'd0);
        send_frame(F_POS_ONE, F_ZERO, F_NEG_HALF, 1'b0);
        send_frame(F_NEG_HALF, F_POS_ONE, F_NEG_ZERO, 1'b0);
        send_frame(F_POS_HALF, F_NEG_ZERO, F_ZERO, 1'b0);
        wait_idle();
        cfg_write(dcfd_pkg::CFG_STEER_CENTER, 24'd2048);
        cfg_write(dcfd_pkg::CFG_ACTUATOR_MAX, 24'd4095);
        cfg_write(dcfd_pkg::CFG_ACTUATOR_MIN, 24'd0);
        cfg_write(dcfd_pkg::CFG_THROTTLE_CAP, {12'hFFF, 12'd4095});
        cfg_write(dcfd_pkg::CFG_BRAKE_THRESHOLD, dcfd_pkg::CFG_DATA_W'(Q_ONE));
        cfg_write(dcfd_pkg::CFG_SPEED_DEADZONE, dcfd_pkg::CFG_DATA_W'(Q_ONE));
        cfg_write(CFG_SPARE_LO, 24'hFFFFFF);
        cfg_write(CFG_SPARE_HI, dcfd_pkg::CFG_DATA_W'($urandom));
        send_frame(F_POS_HALF, F_POS_ONE, F_NEG_ONE, 1'b0);
        send_frame(F_ZERO, q_to_float(1'b1, Q_ONE - 1), F_ZERO, 1'b0);
        wait_idle();
        cfg_write(dcfd_pkg::CFG_BRAKE_THRESHOLD, dcfd_pkg::RST_BRAKE_THRESH);
        cfg_write(dcfd_pkg::CFG_SPEED_DEADZONE, dcfd_pkg::RST_SPEED_DZ);
    endtask

    task automatic test_random_traffic();
        int start_bytes;
        int k;
        start_bytes = sent_bytes;
        while (sent_bytes < start_bytes + RANDOM_BYTES) begin
            wait_idle();
            if ($urandom_range(0, 3) != 0)
                randomize_config();
            idle_en  = ($urandom_range(0, 4) != 0);
            stall_en = ($urandom_range(0, 4) != 0);
            for (int f = 0; f < 12; f++) begin
                k = $urandom_range(0, 9);
                if (k < 8)
                    random_frame();
                else if (k < 9)
                    send_frame(rand_cmd(), rand_cmd(), rand_cmd(), 1'b1);
                else
                    noise_burst($urandom_range(1, 6));
            end
        end
    endtask

    initial begin
        i_rst_n     = 1'b0;
        i_valid     = 1'b0;
        i_rx_byte   = '0;
        i_cfg_wr_en = 1'b0;
        i_cfg_index = '0;
        i_cfg_data  = '0;
        for (int i = 0; i < 13; i++)
            win_bytes[i] = 8'd0;
        win_held   = 0;
        win_chk    = 8'd0;
        cfg_center = dcfd_pkg::RST_STEER_CENTER;
        cfg_amax   = dcfd_pkg::RST_ACTUATOR_MAX;
        cfg_amin   = dcfd_pkg::RST_ACTUATOR_MIN;
        cfg_tcap   = dcfd_pkg::RST_THROTTLE_CAP;
        cfg_bthr   = dcfd_pkg::RST_BRAKE_THRESH;
        cfg_dz     = dcfd_pkg::RST_SPEED_DZ;
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_default_frames();
        test_stream_resync();
        test_register_extremes();
        test_random_traffic();
        wait_idle();
        repeat (20) @(negedge i_clk);
        if (mismatches == 0 && pending_cmds.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
